// ===== design/lpp_pkg.sv =====
// Shared types and constants for the long-press power controller.
package lpp_pkg;

    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int DEB_W    = 8;
    localparam int CNT_W    = 16;
    localparam int PULSE_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE      = 3'd0,
        REG_LONG_PRESS    = 3'd1,
        REG_BLINK_PERIOD  = 3'd2,
        REG_BLINK_ON      = 3'd3,
        REG_BOOT_ON       = 3'd4,
        REG_BOOT_OFF      = 3'd5,
        REG_SHUTDOWN_ON   = 3'd6,
        REG_SHUTDOWN_OFF  = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        MODE_OFF      = 2'd0,
        MODE_BOOTING  = 2'd1,
        MODE_ON       = 2'd2,
        MODE_SHUTDOWN = 2'd3
    } mode_t;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_DEBOUNCE = 5'b00010,
        PH_TIMING   = 5'b00100,
        PH_SEQ      = 5'b01000,
        PH_WAIT     = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [DEB_W-1:0] debounce_ticks;
        logic [CNT_W-1:0] long_press_ticks;
        logic [CNT_W-1:0] hold_blink_period;
        logic [CNT_W-1:0] hold_blink_on;
        logic [CNT_W-1:0] boot_pulse_on;
        logic [CNT_W-1:0] boot_pulse_off;
        logic [CNT_W-1:0] shutdown_pulse_on;
        logic [CNT_W-1:0] shutdown_pulse_off;
    } cfg_t;

    typedef struct packed {
        logic       led;
        logic [1:0] power_state;
        logic       press_timing;
        logic       long_press_event;
        logic       short_press_ignored;
    } result_t;

endpackage

// ===== design/lpp_if.sv =====
// Valid/ready channel interfaces for button samples and controller results.
interface lpp_in_if;
    logic valid;
    logic ready;
    logic button_level;

    modport source (output valid, output button_level, input ready);
    modport sink   (input valid, input button_level, output ready);
endinterface

interface lpp_out_if;
    logic       valid;
    logic       ready;
    logic       led;
    logic [1:0] power_state;
    logic       press_timing;
    logic       long_press_event;
    logic       short_press_ignored;

    modport source (output valid, output led, output power_state, output press_timing,
                    output long_press_event, output short_press_ignored, input ready);
    modport sink   (input valid, input led, input power_state, input press_timing,
                    input long_press_event, input short_press_ignored, output ready);
endinterface

// ===== design/long_press_power_controller.sv =====
// Long-press power button controller: top level.
//
// in_ch carries one raw button sample per millisecond tick (0 pressed,
// 1 released). Each transfer on in_ch yields exactly one result transfer on
// out_ch: LED drive, power state, press timing flag and the one-tick
// long-press and ignored-short-press pulses.
// The result of a sample is on out_ch in the cycle after its transfer.
// Throughput is one sample per cycle while out_ch.ready is high; the next-state
// logic of the press and sequence counters is a single pass between the state
// registers and the result register.
// in_ch.ready is high while the result register is empty or being drained,
// so a stalled receiver holds its result and stalls the input one for one.
// Reset empties the result register, puts power off, press phase idle and
// loads the configuration registers with their defaults (20, 3000, 500,
// 250, 250, 150, 150, 100 ticks). Configuration writes through cfg_wr_en,
// cfg_index and cfg_data take effect at once and are meant for idle time.
module long_press_power_controller #(
    parameter int SEQ_PULSES = 5,
    parameter int TICK_BITS  = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [lpp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lpp_pkg::CFG_W-1:0]      cfg_data,
    lpp_in_if.sink                         in_ch,
    lpp_out_if.source                      out_ch
);
    import lpp_pkg::*;

    cfg_t    cfg;
    result_t result;
    logic    can_load;
    logic    accept;

    assign in_ch.ready = can_load;
    assign accept      = in_ch.valid && can_load;

    lpp_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (cfg_wr_en),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    lpp_core #(
        .SEQ_PULSES (SEQ_PULSES),
        .TICK_BITS  (TICK_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .button_level (in_ch.button_level),
        .cfg          (cfg),
        .result       (result)
    );

    lpp_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .result   (result),
        .can_load (can_load),
        .out_ch   (out_ch)
    );
endmodule

// ===== design/lpp_cfg.sv =====
// Configuration register file for the long-press power controller.
module lpp_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [lpp_pkg::CFG_IDX_W-1:0]  index,
    input  logic [lpp_pkg::CFG_W-1:0]      data,
    output lpp_pkg::cfg_t                  cfg
);
    import lpp_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks     <= DEB_W'(20);
            cfg_reg.long_press_ticks   <= CNT_W'(3000);
            cfg_reg.hold_blink_period  <= CNT_W'(500);
            cfg_reg.hold_blink_on      <= CNT_W'(250);
            cfg_reg.boot_pulse_on      <= CNT_W'(250);
            cfg_reg.boot_pulse_off     <= CNT_W'(150);
            cfg_reg.shutdown_pulse_on  <= CNT_W'(150);
            cfg_reg.shutdown_pulse_off <= CNT_W'(100);
        end
        else if (wr_en)
        begin
            case (reg_idx_t'(index))
                REG_DEBOUNCE:     cfg_reg.debounce_ticks     <= data[DEB_W-1:0];
                REG_LONG_PRESS:   cfg_reg.long_press_ticks   <= data;
                REG_BLINK_PERIOD: cfg_reg.hold_blink_period  <= data;
                REG_BLINK_ON:     cfg_reg.hold_blink_on      <= data;
                REG_BOOT_ON:      cfg_reg.boot_pulse_on      <= data;
                REG_BOOT_OFF:     cfg_reg.boot_pulse_off     <= data;
                REG_SHUTDOWN_ON:  cfg_reg.shutdown_pulse_on  <= data;
                REG_SHUTDOWN_OFF: cfg_reg.shutdown_pulse_off <= data;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;
endmodule

// ===== design/lpp_core.sv =====
// Press timing and power sequencing state with its per-sample next-state logic.
module lpp_core #(
    parameter int SEQ_PULSES = 5,
    parameter int TICK_BITS  = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              button_level,
    input  lpp_pkg::cfg_t     cfg,
    output lpp_pkg::result_t  result
);
    import lpp_pkg::*;

    localparam int CMP_W = (TICK_BITS > CNT_W) ? TICK_BITS : CNT_W;
    localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

    mode_t                mode_reg, mode_next;
    phase_t               phase_reg, phase_next;
    logic                 last_reg, last_next;
    logic [TICK_BITS-1:0] hold_reg, hold_next;
    logic [CNT_W-1:0]     blink_reg, blink_next;
    logic [PULSE_W-1:0]   pidx_reg, pidx_next;
    logic                 lit_reg, lit_next;
    logic [CNT_W-1:0]     pcnt_reg, pcnt_next;

    logic [TICK_BITS-1:0] hold_adv;
    logic [CNT_W-1:0]     blink_inc, blink_adv;
    logic [CMP_W-1:0]     hold_cmp;
    logic                 do_eval;
    logic                 led, ev, ign;
    logic                 boot;
    logic [CNT_W-1:0]     on_t, off_t, pcnt_t;
    logic [PULSE_W-1:0]   pidx_t;
    logic                 seq_done;

    always_comb
    begin
        hold_adv  = (hold_reg == TICK_MAX) ? hold_reg : hold_reg + 1'b1;
        blink_inc = blink_reg + 1'b1;
        blink_adv = (cfg.hold_blink_period != '0 && blink_inc >= cfg.hold_blink_period)
                    ? '0 : blink_inc;
        boot      = (mode_reg == MODE_BOOTING);
        on_t      = boot ? cfg.boot_pulse_on  : cfg.shutdown_pulse_on;
        off_t     = boot ? cfg.boot_pulse_off : cfg.shutdown_pulse_off;
    end

    always_comb
    begin
        mode_next  = mode_reg;
        phase_next = phase_reg;
        last_next  = button_level;
        hold_next  = hold_reg;
        blink_next = blink_reg;
        pidx_next  = pidx_reg;
        lit_next   = lit_reg;
        pcnt_next  = pcnt_reg;
        led        = (mode_reg == MODE_ON);
        ev         = 1'b0;
        ign        = 1'b0;
        do_eval    = 1'b0;
        pcnt_t     = pcnt_reg;
        pidx_t     = pidx_reg;
        seq_done   = 1'b0;
        hold_cmp   = '0;

        case (phase_reg)
            PH_DEBOUNCE:
            begin
                hold_next  = hold_adv;
                blink_next = blink_adv;
                if (CMP_W'(hold_adv) >= CMP_W'(cfg.debounce_ticks))
                begin
                    if (!button_level)
                        do_eval = 1'b1;
                    else
                        phase_next = PH_IDLE;
                end
            end
            PH_TIMING:
            begin
                hold_next  = hold_adv;
                blink_next = blink_adv;
                do_eval    = 1'b1;
            end
            PH_SEQ:
            begin
                if (lit_reg)
                begin
                    if (pcnt_reg >= on_t)
                    begin
                        lit_next = 1'b0;
                        pcnt_t   = '0;
                    end
                end
                else if (pcnt_reg >= off_t)
                begin
                    pcnt_t = '0;
                    pidx_t = pidx_reg + 1'b1;
                    if (32'(pidx_t) >= SEQ_PULSES)
                        seq_done = 1'b1;
                    else
                        lit_next = 1'b1;
                end
                if (seq_done)
                begin
                    mode_next  = boot ? MODE_ON : MODE_OFF;
                    phase_next = PH_WAIT;
                    pidx_next  = '0;
                    pcnt_next  = pcnt_t;
                    led        = !boot ? 1'b0 : 1'b1;
                end
                else
                begin
                    pidx_next = pidx_t;
                    led       = lit_next;
                    pcnt_next = pcnt_t + 1'b1;
                end
            end
            PH_WAIT:
            begin
                if (button_level)
                    phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (last_reg && !button_level)
                begin
                    hold_next  = '0;
                    blink_next = '0;
                    if (cfg.debounce_ticks == '0)
                        do_eval = 1'b1;
                    else
                        phase_next = PH_DEBOUNCE;
                end
            end
        endcase

        if (do_eval)
        begin
            hold_cmp = CMP_W'(hold_next);
            if (button_level)
            begin
                ign        = 1'b1;
                phase_next = PH_IDLE;
            end
            else if (hold_cmp >= CMP_W'(cfg.long_press_ticks))
            begin
                ev         = 1'b1;
                mode_next  = (mode_reg == MODE_ON) ? MODE_SHUTDOWN : MODE_BOOTING;
                phase_next = PH_SEQ;
                pidx_next  = '0;
                lit_next   = 1'b1;
                pcnt_next  = CNT_W'(1);
                led        = 1'b1;
            end
            else
            begin
                phase_next = PH_TIMING;
                if (mode_reg == MODE_OFF)
                    led = (blink_next < cfg.hold_blink_on);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_OFF;
            phase_reg <= PH_IDLE;
            last_reg  <= 1'b1;
            hold_reg  <= '0;
            blink_reg <= '0;
            pidx_reg  <= '0;
            lit_reg   <= 1'b0;
            pcnt_reg  <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            last_reg  <= last_next;
            hold_reg  <= hold_next;
            blink_reg <= blink_next;
            pidx_reg  <= pidx_next;
            lit_reg   <= lit_next;
            pcnt_reg  <= pcnt_next;
        end
    end

    assign result.led                 = led;
    assign result.power_state         = mode_next;
    assign result.press_timing        = (phase_next == PH_TIMING);
    assign result.long_press_event    = ev;
    assign result.short_press_ignored = ign;
endmodule

// ===== design/lpp_out.sv =====
// Result register between the sample logic and the output channel.
module lpp_out (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  lpp_pkg::result_t  result,
    output logic              can_load,
    lpp_out_if.source         out_ch
);
    import lpp_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign can_load = !valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (out_ch.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= result;
    end

    assign out_ch.valid               = valid_reg;
    assign out_ch.led                 = res_reg.led;
    assign out_ch.power_state         = res_reg.power_state;
    assign out_ch.press_timing        = res_reg.press_timing;
    assign out_ch.long_press_event    = res_reg.long_press_event;
    assign out_ch.short_press_ignored = res_reg.short_press_ignored;
endmodule

// ===== design/lpp_checker.sv =====
// Port-level checks for the long-press power controller, bound to the top level.
module lpp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       led,
    input logic [1:0] power_state,
    input logic       press_timing,
    input logic       long_press_event,
    input logic       short_press_ignored
);
    import lpp_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("sample transfer produced no result");

    a_event_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && long_press_event |->
            led && !press_timing &&
            (power_state == MODE_BOOTING || power_state == MODE_SHUTDOWN))
        else $error("long press result inconsistent");

    a_ignore_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && short_press_ignored |-> !long_press_event && !press_timing)
        else $error("ignored press result inconsistent");
endmodule

bind long_press_power_controller lpp_checker u_lpp_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_ch.valid),
    .in_ready            (in_ch.ready),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .led                 (out_ch.led),
    .power_state         (out_ch.power_state),
    .press_timing        (out_ch.press_timing),
    .long_press_event    (out_ch.long_press_event),
    .short_press_ignored (out_ch.short_press_ignored)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for long_press_power_controller: random button samples checked against a predictor.
module tb_top;
    import lpp_pkg::*;

    localparam int PULSES_PER_SEQ = 5;
    localparam int CYCLE_LIMIT    = 1000000;

    class power_button_scoreboard;
        cfg_t        cfg;
        mode_t       mode;
        phase_t      phase;
        bit          prev_level;
        logic [15:0] hold_ticks;
        logic [15:0] blink_ticks;
        logic [15:0] phase_ticks;
        logic [2:0]  pulse_num;
        bit          pulse_on;
        result_t     pending_status[$];
        int unsigned samples_in;
        int unsigned results_seen;
        int unsigned mismatches;

        function new();
            cfg.debounce_ticks     = 8'd20;
            cfg.long_press_ticks   = 16'd3000;
            cfg.hold_blink_period  = 16'd500;
            cfg.hold_blink_on      = 16'd250;
            cfg.boot_pulse_on      = 16'd250;
            cfg.boot_pulse_off     = 16'd150;
            cfg.shutdown_pulse_on  = 16'd150;
            cfg.shutdown_pulse_off = 16'd100;
            mode         = MODE_OFF;
            phase        = PH_IDLE;
            prev_level   = 1'b1;
            hold_ticks   = '0;
            blink_ticks  = '0;
            phase_ticks  = '0;
            pulse_num    = '0;
            pulse_on     = 1'b0;
            samples_in   = 0;
            results_seen = 0;
            mismatches   = 0;
        endfunction

        function void step_clocks();
            logic [15:0] nb;
            if (hold_ticks != '1)
                hold_ticks++;
            nb = blink_ticks + 16'd1;
            if (cfg.hold_blink_period != 0 && nb >= cfg.hold_blink_period)
                nb = '0;
            blink_ticks = nb;
        endfunction

        function void evaluate_hold(input bit level, inout bit lit, inout bit fired,
                                    inout bit ignored);
            if (level)
            begin
                ignored = 1'b1;
                phase   = PH_IDLE;
                lit     = (mode == MODE_ON);
            end
            else if (hold_ticks >= cfg.long_press_ticks)
            begin
                fired = 1'b1;
                if (mode == MODE_ON)
                    mode = MODE_SHUTDOWN;
                else
                    mode = MODE_BOOTING;
                phase       = PH_SEQ;
                pulse_num   = '0;
                pulse_on    = 1'b1;
                phase_ticks = 16'd1;
                lit         = 1'b1;
            end
            else
            begin
                phase = PH_TIMING;
                if (mode == MODE_OFF)
                    lit = (blink_ticks < cfg.hold_blink_on);
                else
                    lit = (mode == MODE_ON);
            end
        endfunction

        function void run_pulses(inout bit lit);
            bit          boot;
            logic [15:0] on_t;
            logic [15:0] off_t;
            boot  = (mode == MODE_BOOTING);
            on_t  = boot ? cfg.boot_pulse_on : cfg.shutdown_pulse_on;
            off_t = boot ? cfg.boot_pulse_off : cfg.shutdown_pulse_off;
            if (pulse_on)
            begin
                if (phase_ticks >= on_t)
                begin
                    pulse_on    = 1'b0;
                    phase_ticks = '0;
                end
            end
            else if (phase_ticks >= off_t)
            begin
                phase_ticks = '0;
                pulse_num   = pulse_num + 3'd1;
                if (pulse_num >= PULSES_PER_SEQ)
                begin
                    if (boot)
                        mode = MODE_ON;
                    else
                        mode = MODE_OFF;
                    phase     = PH_WAIT;
                    pulse_num = '0;
                    lit       = (mode == MODE_ON);
                    return;
                end
                pulse_on = 1'b1;
            end
            lit = pulse_on;
            phase_ticks++;
        endfunction

        function result_t next_status(input bit level);
            result_t r;
            bit      lit;
            bit      fired;
            bit      ignored;
            lit     = (mode == MODE_ON);
            fired   = 1'b0;
            ignored = 1'b0;
            case (phase)
                PH_DEBOUNCE:
                begin
                    step_clocks();
                    if (hold_ticks >= cfg.debounce_ticks)
                    begin
                        if (!level)
                            evaluate_hold(1'b0, lit, fired, ignored);
                        else
                            phase = PH_IDLE;
                    end
                end
                PH_TIMING:
                begin
                    step_clocks();
                    evaluate_hold(level, lit, fired, ignored);
                end
                PH_SEQ:
                    run_pulses(lit);
                PH_WAIT:
                begin
                    if (level)
                        phase = PH_IDLE;
                end
                default:
                begin
                    phase = PH_IDLE;
                    if (prev_level && !level)
                    begin
                        hold_ticks  = '0;
                        blink_ticks = '0;
                        if (cfg.debounce_ticks == 0)
                            evaluate_hold(1'b0, lit, fired, ignored);
                        else
                            phase = PH_DEBOUNCE;
                    end
                end
            endcase
            prev_level            = level;
            r.led                 = lit;
            r.power_state         = mode;
            r.press_timing        = (phase == PH_TIMING);
            r.long_press_event    = fired;
            r.short_press_ignored = ignored;
            return r;
        endfunction

        function void note_sample(input bit level);
            pending_status.push_back(next_status(level));
            samples_in++;
        endfunction

        task report_mismatch(input string what);
            mismatches++;
            if (mismatches <= 30)
                $display("MISMATCH result %0d: %s", results_seen, what);
        endtask

        task check_result(input result_t got);
            result_t want;
            results_seen++;
            if (pending_status.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %b", got));
                return;
            end
            want = pending_status.pop_front();
            if (got.led !== want.led)
                report_mismatch($sformatf("led %b, expected %b", got.led, want.led));
            if (got.power_state !== want.power_state)
                report_mismatch($sformatf("power_state %0d, expected %0d",
                                          got.power_state, want.power_state));
            if (got.press_timing !== want.press_timing)
                report_mismatch($sformatf("press_timing %b, expected %b",
                                          got.press_timing, want.press_timing));
            if (got.long_press_event !== want.long_press_event)
                report_mismatch($sformatf("long_press_event %b, expected %b",
                                          got.long_press_event, want.long_press_event));
            if (got.short_press_ignored !== want.short_press_ignored)
                report_mismatch($sformatf("short_press_ignored %b, expected %b",
                                          got.short_press_ignored, want.short_press_ignored));
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int unsigned          cycle_count = 0;
    int unsigned          idle_pct = 20;
    bit                   quiet = 1'b0;

    power_button_scoreboard sb;

    lpp_in_if  in_ch();
    lpp_out_if out_ch();

    long_press_power_controller #(
        .SEQ_PULSES (PULSES_PER_SEQ),
        .TICK_BITS  (16)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** long_press_power_controller: FAILED **");
            $finish;
        end
    end

    // Result side: checks each transfer, random stalls, one long hold-off.
    initial
    begin
        int unsigned hold_left;
        bit          pressure_done;
        hold_left     = 0;
        pressure_done = 1'b0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                sb.check_result({out_ch.led, out_ch.power_state, out_ch.press_timing,
                                 out_ch.long_press_event, out_ch.short_press_ignored});
            if (!pressure_done && sb.samples_in >= 400)
            begin
                pressure_done = 1'b1;
                hold_left     = 300;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 99) < idle_pct)
            begin
                hold_left = $urandom_range(0, 15);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    function automatic cfg_t make_cfg(input int unsigned deb, input int unsigned thr,
                                      input int unsigned per, input int unsigned lit,
                                      input int unsigned b_on, input int unsigned b_off,
                                      input int unsigned s_on, input int unsigned s_off);
        cfg_t c;
        c.debounce_ticks     = 8'(deb);
        c.long_press_ticks   = 16'(thr);
        c.hold_blink_period  = 16'(per);
        c.hold_blink_on      = 16'(lit);
        c.boot_pulse_on      = 16'(b_on);
        c.boot_pulse_off     = 16'(b_off);
        c.shutdown_pulse_on  = 16'(s_on);
        c.shutdown_pulse_off = 16'(s_off);
        return c;
    endfunction

    function automatic cfg_t small_cfg();
        return make_cfg($urandom_range(0, 5), $urandom_range(0, 24), $urandom_range(0, 9),
                        $urandom_range(0, 10), $urandom_range(0, 5), $urandom_range(0, 5),
                        $urandom_range(0, 5), $urandom_range(0, 5));
    endfunction

    function automatic logic [CFG_W-1:0] reg_value(input cfg_t c, input reg_idx_t idx);
        case (idx)
            // upper byte of the debounce write is don't-care
            REG_DEBOUNCE:     return {8'($urandom_range(0, 255)), c.debounce_ticks};
            REG_LONG_PRESS:   return c.long_press_ticks;
            REG_BLINK_PERIOD: return c.hold_blink_period;
            REG_BLINK_ON:     return c.hold_blink_on;
            REG_BOOT_ON:      return c.boot_pulse_on;
            REG_BOOT_OFF:     return c.boot_pulse_off;
            REG_SHUTDOWN_ON:  return c.shutdown_pulse_on;
            default:          return c.shutdown_pulse_off;
        endcase
    endfunction

    task automatic load_config(input cfg_t c);
        reg_idx_t idx;
        idx = idx.first();
        cfg_wr_en <= 1'b1;
        do
        begin
            cfg_index <= idx;
            cfg_data  <= reg_value(c, idx);
            @(posedge clk);
            idx = idx.next();
        end
        while (idx != idx.first());
        cfg_wr_en <= 1'b0;
        sb.cfg = c;
    endtask

    task automatic send_sample(input bit level);
        if (!quiet && $urandom_range(0, 99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.button_level <= level;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_sample(level);
    endtask

    task automatic play(input string pattern);
        for (int i = 0; i < pattern.len(); i++)
            send_sample(pattern.getc(i) != "0");
    endtask

    // Release gap, then a press that fails debounce, is released early, or is held
    // past the threshold; some bursts are pure chatter or end in bounce.
    task automatic press_burst(input bit allow_long);
        int unsigned kind;
        int unsigned len;
        int unsigned deb;
        int unsigned thr;
        int unsigned reach;
        deb   = sb.cfg.debounce_ticks;
        thr   = sb.cfg.long_press_ticks;
        reach = (thr > deb) ? thr : deb;
        kind  = $urandom_range(0, 9);
        repeat ($urandom_range(1, 6)) send_sample(1'b1);
        if (kind == 0)
            repeat ($urandom_range(1, 12)) send_sample(1'($urandom_range(0, 1)));
        else
        begin
            if (kind <= 2)
                len = $urandom_range(1, deb + 1);
            else if (kind <= 5 || !allow_long)
                len = deb + 1 + $urandom_range(0, (thr < 300) ? thr : 300);
            else
                len = reach + 1 + $urandom_range(0, 12);
            repeat (len) send_sample(1'b0);
            if (kind == 9)
                repeat ($urandom_range(1, 4)) send_sample(1'($urandom_range(0, 1)));
        end
    endtask

    // Bring the controller back to idle and drain all results before a register write.
    task automatic end_phase();
        while (sb.phase != PH_IDLE)
            send_sample(1'b1);
        in_ch.valid <= 1'b0;
        while (sb.pending_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(input cfg_t c, input int unsigned count, input bit allow_long);
        int unsigned target;
        load_config(c);
        target = sb.samples_in + count;
        while (sb.samples_in < target)
            press_burst(allow_long);
        end_phase();
    endtask

    initial
    begin
        sb = new();
        rst_n              <= 1'b0;
        cfg_wr_en          <= 1'b0;
        cfg_index          <= REG_DEBOUNCE;
        cfg_data           <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.button_level <= 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: edge that fails the debounce check
        play("1001");
        end_phase();
        // all zero: confirm and fire on the edge, one-tick pulses
        load_config(make_cfg(0, 0, 0, 0, 0, 0, 0, 0));
        play("10");
        end_phase();
        // debounce failure, ignored press, shutdown, then blink and boot from off
        load_config(make_cfg(2, 4, 3, 2, 1, 2, 2, 1));
        play("00110001000001");
        end_phase();
        play("0000001");
        end_phase();

        idle_pct = 25;
        run_phase(make_cfg(20, 3000, 500, 250, 250, 150, 150, 100), 150, 1'b0);
        run_phase(make_cfg(255, 65535, 65535, 65535, 65535, 65535, 65535, 65535), 200, 1'b0);
        run_phase(make_cfg(0, 1, 1, 0, 1, 1, 1, 1), 150, 1'b1);
        for (int p = 0; p < 6; p++)
        begin
            idle_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 15 : 40);
            run_phase(small_cfg(), 180, 1'b1);
        end
        quiet = 1'b1;
        run_phase(small_cfg(), 150, 1'b1);

        if (sb.mismatches == 0 && sb.pending_status.size() == 0)
            $display("** long_press_power_controller: PASSED **");
        else
            $display("** long_press_power_controller: FAILED **");
        $finish;
    end
endmodule
